/* sv/dlvc_pkg.sv */
// shared types, constants and helpers for the display list vertex cache
package dlvc_pkg;

   localparam int CACHE_ENTRIES_DEF = 32;

   // channel widths
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 112;

   // field widths
   localparam int WORD_W   = 32;
   localparam int COORD_W  = 16;
   localparam int COLOR_W  = 32;
   localparam int POS_W    = 3 * COORD_W;
   localparam int ATTR_W   = 2 * COORD_W + COLOR_W;
   localparam int IDX_W    = 7;
   localparam int OPCODE_W = 8;
   localparam int MAX_OPS  = 6;
   localparam int OP_CNT_W = 3;

   // command word bit positions
   localparam int LIGHT_BIT    = 17;
   localparam int CALL_END_BIT = 16;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_CMD     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VERTEX  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_NOOP       = 8'h00;
   localparam logic [OPCODE_W-1:0] OP_VTX_LOAD   = 8'h01;
   localparam logic [OPCODE_W-1:0] OP_TRI1       = 8'h05;
   localparam logic [OPCODE_W-1:0] OP_TRI2       = 8'h06;
   localparam logic [OPCODE_W-1:0] OP_TRI2_ALT   = 8'hb1;
   localparam logic [OPCODE_W-1:0] OP_LIGHTING   = 8'hd9;
   localparam logic [OPCODE_W-1:0] OP_CALL       = 8'hde;
   localparam logic [OPCODE_W-1:0] OP_END_LIST   = 8'hdf;
   localparam logic [OPCODE_W-1:0] OP_PRIM_COLOR = 8'hfa;
   localparam logic [OPCODE_W-1:0] OP_SKIP_E1    = 8'he1;
   localparam logic [OPCODE_W-1:0] OP_SKIP_E3    = 8'he3;
   localparam logic [OPCODE_W-1:0] OP_SKIP_E6    = 8'he6;
   localparam logic [OPCODE_W-1:0] OP_SKIP_E7    = 8'he7;
   localparam logic [OPCODE_W-1:0] OP_SKIP_E8    = 8'he8;
   localparam logic [OPCODE_W-1:0] OP_SKIP_E9    = 8'he9;
   localparam logic [OPCODE_W-1:0] OP_SKIP_F1    = 8'hf1;
   localparam logic [OPCODE_W-1:0] OP_SKIP_F2    = 8'hf2;
   localparam logic [OPCODE_W-1:0] OP_SKIP_F3    = 8'hf3;
   localparam logic [OPCODE_W-1:0] OP_SKIP_F4    = 8'hf4;
   localparam logic [OPCODE_W-1:0] OP_SKIP_F5    = 8'hf5;
   localparam logic [OPCODE_W-1:0] OP_SKIP_FC    = 8'hfc;
   localparam logic [OPCODE_W-1:0] OP_SKIP_FD    = 8'hfd;

   localparam logic [COLOR_W-1:0] PRIM_COLOR_RESET = 32'hffff_ffff;

   typedef enum logic [STATUS_W-1:0] {
      ST_VERTEX      = 3'd0,
      ST_REJECT      = 3'd1,
      ST_UNSUPPORTED = 3'd2,
      ST_END         = 3'd3,
      ST_CALL        = 3'd4,
      ST_CALL_END    = 3'd5,
      ST_BAD_LOAD    = 3'd6
   } status_type;

   // one queued result: a cache read or a bare status
   typedef struct packed {
      status_type             status;
      logic                   last;
      logic [IDX_W-1:0]       index;
   } op_type;

   typedef struct packed {
      logic                   load;
      logic [OP_CNT_W-1:0]    count;
      op_type [MAX_OPS-1:0]   ops;
   } seq_load_type;

   function automatic op_type make_op(input status_type s, input logic [IDX_W-1:0] idx);
      op_type o;
      o.status = s;
      o.last   = 1'b0;
      o.index  = idx;
      return o;
   endfunction

endpackage

/* sv/display_list_vertex_cache.sv */
// top level of the display list vertex cache
// a result is queued with its command, then passes the ram data stage and the response register
// one request is taken per cycle, or one result per cycle when a request emits several, as
//   long as the response side takes them; the single cache read port serialises the corners
// reset: clears valid bits, counters and the result pipeline, turns lighting on and sets
//   the primitive colour to all ones; the cache rams are not cleared and need no sweep
module display_list_vertex_cache #(
   parameter int CACHE_ENTRIES = dlvc_pkg::CACHE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // command_high, command_low, vertex_x, vertex_y, vertex_z, vertex_s, vertex_t, vertex_rgba
   input  logic [dlvc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind
   input  logic [dlvc_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_x, out_y, out_z, out_s, out_t, red, green, blue, alpha
   output logic [dlvc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [dlvc_pkg::STATUS_W-1:0]     rsp_tuser,
   output logic                              rsp_tlast
);

   import dlvc_pkg::*;

   localparam int ADDR_W = $clog2(CACHE_ENTRIES);

   logic              req_fire;
   logic              can_load;
   seq_load_type      seq_load;

   // cache write side, driven by vertex records
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [POS_W-1:0]  wr_pos;
   logic [ATTR_W-1:0] wr_attr;

   // cache read side, driven by the sequencer
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [POS_W-1:0]  rd_pos;
   logic [ATTR_W-1:0] rd_attr;

   // requests wait only while a result list is still issuing its results; the ram returns old
   // data when the final read and a new write meet on one entry, which keeps request order
   assign req_tready = can_load;
   assign req_fire   = req_tvalid && req_tready;

   dlvc_decode #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_kind (req_tuser),
      .req_data (req_tdata),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_pos   (wr_pos),
      .wr_attr  (wr_attr),
      .seq_load (seq_load)
   );

   // x, y, z per entry
   dlvc_ram #(
      .WIDTH (POS_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_pos_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_pos),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (rd_pos)
   );

   // s, t and stored colour per entry
   dlvc_ram #(
      .WIDTH (ATTR_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_attr_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_attr),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (rd_attr)
   );

   // issue, ram data stage and response register
   dlvc_seq #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .seq_load   (seq_load),
      .can_load   (can_load),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_pos     (rd_pos),
      .rd_attr    (rd_attr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* sv/dlvc_ram.sv */
// generic single write, single read ram with registered read data
module dlvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/dlvc_decode.sv */
// request decode, cache bookkeeping state and result list build
module dlvc_decode #(
   parameter int CACHE_ENTRIES = dlvc_pkg::CACHE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_fire,
   input  logic [dlvc_pkg::KIND_W-1:0]         req_kind,
   input  logic [dlvc_pkg::REQ_DATA_W-1:0]     req_data,
   output logic                                wr_en,
   output logic [$clog2(CACHE_ENTRIES)-1:0]    wr_addr,
   output logic [dlvc_pkg::POS_W-1:0]          wr_pos,
   output logic [dlvc_pkg::ATTR_W-1:0]         wr_attr,
   output dlvc_pkg::seq_load_type              seq_load
);

   import dlvc_pkg::*;

   localparam int ADDR_W = $clog2(CACHE_ENTRIES);
   localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);

   logic [CACHE_ENTRIES-1:0] valid_ff, valid_in;
   logic                     lighting_ff, lighting_in;
   logic [COLOR_W-1:0]       colour_ff, colour_in;
   logic [CNT_W-1:0]         pending_ff, pending_in;
   logic [CNT_W-1:0]         slot_ff, slot_in;

   logic [WORD_W-1:0]   cmd_high, cmd_low;
   logic [COORD_W-1:0]  vx, vy, vz, vs, vt;
   logic [COLOR_W-1:0]  vrgba;
   logic [OPCODE_W-1:0] opcode;
   logic [7:0]          load_count;
   logic [IDX_W-1:0]    load_last;
   logic [7:0]          load_first;
   logic                load_bad;
   logic [IDX_W-1:0]    a1, b1, c1, a2, b2, c2;
   logic                ok1, ok2;
   op_type [MAX_OPS-1:0] ops;
   logic [OP_CNT_W-1:0] n_ops;

   function automatic logic usable(input logic [IDX_W-1:0] idx,
                                   input logic [CACHE_ENTRIES-1:0] vbits);
      return (idx < IDX_W'(CACHE_ENTRIES)) && vbits[idx[ADDR_W-1:0]];
   endfunction

   assign cmd_high = req_data[31:0];
   assign cmd_low  = req_data[63:32];
   assign vx       = req_data[79:64];
   assign vy       = req_data[95:80];
   assign vz       = req_data[111:96];
   assign vs       = req_data[127:112];
   assign vt       = req_data[143:128];
   assign vrgba    = req_data[175:144];

   assign opcode     = cmd_high[31:24];
   assign load_count = cmd_high[19:12];
   assign load_last  = cmd_high[7:1];
   assign load_first = {1'b0, load_last} - load_count;
   // range check: count fits, the span starts at or above zero and ends inside the cache
   assign load_bad   = (load_count > 8'(CACHE_ENTRIES)) || ({1'b0, load_last} < load_count)
                       || (load_last > IDX_W'(CACHE_ENTRIES));

   assign a1 = cmd_high[23:17];
   assign b1 = cmd_high[15:9];
   assign c1 = cmd_high[7:1];
   assign a2 = cmd_low[23:17];
   assign b2 = cmd_low[15:9];
   assign c2 = cmd_low[7:1];
   assign ok1 = usable(a1, valid_ff) && usable(b1, valid_ff) && usable(c1, valid_ff);
   assign ok2 = usable(a2, valid_ff) && usable(b2, valid_ff) && usable(c2, valid_ff);

   assign wr_addr = slot_ff[ADDR_W-1:0];
   assign wr_pos  = {vx, vy, vz};
   assign wr_attr = {vs, vt, (lighting_ff ? colour_ff : vrgba)};

   always_comb begin
      valid_in    = valid_ff;
      lighting_in = lighting_ff;
      colour_in   = colour_ff;
      pending_in  = pending_ff;
      slot_in     = slot_ff;
      wr_en       = 1'b0;
      ops         = '0;
      n_ops       = '0;
      if (req_fire) begin
         case (req_kind)
            KIND_CMD: begin
               pending_in = '0;
               case (opcode)
                  OP_NOOP, OP_SKIP_E1, OP_SKIP_E3, OP_SKIP_E6, OP_SKIP_E7, OP_SKIP_E8,
                  OP_SKIP_E9, OP_SKIP_F1, OP_SKIP_F2, OP_SKIP_F3, OP_SKIP_F4, OP_SKIP_F5,
                  OP_SKIP_FC, OP_SKIP_FD: begin
                  end
                  OP_VTX_LOAD: begin
                     if (load_bad) begin
                        ops[0] = make_op(ST_BAD_LOAD, '0);
                        n_ops  = OP_CNT_W'(1);
                     end else begin
                        pending_in = load_count[CNT_W-1:0];
                        slot_in    = load_first[CNT_W-1:0];
                     end
                  end
                  OP_TRI1, OP_TRI2, OP_TRI2_ALT: begin
                     if (ok1) begin
                        ops[0] = make_op(ST_VERTEX, a1);
                        ops[1] = make_op(ST_VERTEX, b1);
                        ops[2] = make_op(ST_VERTEX, c1);
                        n_ops  = OP_CNT_W'(3);
                     end else begin
                        ops[0] = make_op(ST_REJECT, '0);
                        n_ops  = OP_CNT_W'(1);
                     end
                     // second triangle appends after the first
                     if (opcode != OP_TRI1) begin
                        if (ok2) begin
                           ops[n_ops]                  = make_op(ST_VERTEX, a2);
                           ops[n_ops + OP_CNT_W'(1)]   = make_op(ST_VERTEX, b2);
                           ops[n_ops + OP_CNT_W'(2)]   = make_op(ST_VERTEX, c2);
                           n_ops                       = n_ops + OP_CNT_W'(3);
                        end else begin
                           ops[n_ops] = make_op(ST_REJECT, '0);
                           n_ops      = n_ops + OP_CNT_W'(1);
                        end
                     end
                  end
                  OP_LIGHTING: begin
                     lighting_in = cmd_high[LIGHT_BIT] | cmd_low[LIGHT_BIT];
                  end
                  OP_PRIM_COLOR: begin
                     colour_in = cmd_low;
                  end
                  OP_CALL: begin
                     ops[0] = make_op(cmd_high[CALL_END_BIT] ? ST_CALL_END : ST_CALL, '0);
                     n_ops  = OP_CNT_W'(1);
                  end
                  OP_END_LIST: begin
                     ops[0] = make_op(ST_END, '0);
                     n_ops  = OP_CNT_W'(1);
                  end
                  default: begin
                     ops[0] = make_op(ST_UNSUPPORTED, '0);
                     n_ops  = OP_CNT_W'(1);
                  end
               endcase
            end
            KIND_VERTEX: begin
               if ((pending_ff != '0) && (slot_ff < CNT_W'(CACHE_ENTRIES))) begin
                  wr_en                         = 1'b1;
                  valid_in[slot_ff[ADDR_W-1:0]] = 1'b1;
                  slot_in                       = slot_ff + CNT_W'(1);
                  pending_in                    = pending_ff - CNT_W'(1);
               end
            end
            KIND_RESTART: begin
               valid_in    = '0;
               lighting_in = 1'b1;
               colour_in   = PRIM_COLOR_RESET;
               pending_in  = '0;
            end
            default: begin
            end
         endcase
         if (n_ops != '0) begin
            ops[n_ops - OP_CNT_W'(1)].last = 1'b1;
         end
      end
   end

   assign seq_load.load  = (n_ops != '0);
   assign seq_load.count = n_ops;
   assign seq_load.ops   = ops;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         lighting_ff <= 1'b1;
         colour_ff   <= PRIM_COLOR_RESET;
         pending_ff  <= '0;
         slot_ff     <= '0;
      end else begin
         valid_ff    <= valid_in;
         lighting_ff <= lighting_in;
         colour_ff   <= colour_in;
         pending_ff  <= pending_in;
         slot_ff     <= slot_in;
      end
   end

endmodule

/* sv/dlvc_seq.sv */
// result sequencer: one cache read per cycle unless stalled; drives response register
module dlvc_seq #(
   parameter int CACHE_ENTRIES = dlvc_pkg::CACHE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dlvc_pkg::seq_load_type              seq_load,
   output logic                                can_load,
   output logic                                rd_en,
   output logic [$clog2(CACHE_ENTRIES)-1:0]    rd_addr,
   input  logic [dlvc_pkg::POS_W-1:0]          rd_pos,
   input  logic [dlvc_pkg::ATTR_W-1:0]         rd_attr,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dlvc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [dlvc_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic                                rsp_tlast
);

   import dlvc_pkg::*;

   localparam int ADDR_W = $clog2(CACHE_ENTRIES);

   op_type [MAX_OPS-1:0] op_ff, op_in;
   logic [OP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                 d_valid_ff, d_valid_in;
   op_type               d_op_ff;
   logic                 o_valid_ff, o_valid_in;
   logic [RSP_DATA_W-1:0] o_data_ff;
   status_type           o_status_ff;
   logic                 o_last_ff;
   logic                 busy, issue, o_free, d_free, d_move;

   assign busy     = (cnt_ff != '0);
   assign o_free   = !o_valid_ff || rsp_tready;
   assign d_free   = !d_valid_ff || o_free;
   assign d_move   = d_valid_ff && o_free;
   assign issue    = busy && d_free;
   assign can_load = !busy || ((cnt_ff == OP_CNT_W'(1)) && issue);

   assign rd_en   = issue && (op_ff[0].status == ST_VERTEX);
   assign rd_addr = op_ff[0].index[ADDR_W-1:0];

   always_comb begin
      op_in  = op_ff;
      cnt_in = cnt_ff;
      if (seq_load.load) begin
         op_in  = seq_load.ops;
         cnt_in = seq_load.count;
      end else if (issue) begin
         for (int i = 0; i < MAX_OPS - 1; i++) begin
            op_in[i] = op_ff[i + 1];
         end
         cnt_in = cnt_ff - OP_CNT_W'(1);
      end
      d_valid_in = issue || (d_valid_ff && !o_free);
      o_valid_in = d_move || (o_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         d_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         d_valid_ff <= d_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      if (issue) begin
         d_op_ff <= op_ff[0];
      end
      if (d_move) begin
         o_status_ff <= d_op_ff.status;
         o_last_ff   <= d_op_ff.last;
         if (d_op_ff.status == ST_VERTEX) begin
            o_data_ff <= {rd_attr[7:0], rd_attr[15:8], rd_attr[23:16], rd_attr[31:24],
                          rd_attr[47:32], rd_attr[63:48],
                          rd_pos[15:0], rd_pos[31:16], rd_pos[47:32]};
         end else begin
            o_data_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_data_ff;
   assign rsp_tuser  = o_status_ff;
   assign rsp_tlast  = o_last_ff;

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      seq_load.load |-> can_load)
      else $error("result list loaded while sequencer busy");

   a_final_op_last: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == OP_CNT_W'(1)) |-> op_ff[0].last)
      else $error("final queued result lacks last flag");

   a_inner_op_not_last: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff > OP_CNT_W'(1)) |-> !op_ff[0].last)
      else $error("last flag set before end of result list");

   a_status_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_VERTEX)) |-> (rsp_tdata == '0))
      else $error("status result carries vertex data");
`endif

endmodule

/* sim/display_list_vertex_cache_tb.sv */
// testbench for display_list_vertex_cache: directed and random display lists, checked by a predictor
module display_list_vertex_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dlvc_pkg::*;

   localparam int CACHE_ENTRIES = CACHE_ENTRIES_DEF;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [OPCODE_W-1:0] SKIP_OPCODES [0:13] = '{
      OP_NOOP, OP_SKIP_E1, OP_SKIP_E3, OP_SKIP_E6, OP_SKIP_E7, OP_SKIP_E8, OP_SKIP_E9,
      OP_SKIP_F1, OP_SKIP_F2, OP_SKIP_F3, OP_SKIP_F4, OP_SKIP_F5, OP_SKIP_FC, OP_SKIP_FD
   };

   // request tdata layout, lowest field last
   typedef struct packed {
      logic [COLOR_W-1:0] rgba;
      logic [COORD_W-1:0] t;
      logic [COORD_W-1:0] s;
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
      logic [WORD_W-1:0]  command_low;
      logic [WORD_W-1:0]  command_high;
   } request_fields_type;

   // response tdata layout, also the layout of one cache entry
   typedef struct packed {
      logic [7:0]         alpha;
      logic [7:0]         blue;
      logic [7:0]         green;
      logic [7:0]         red;
      logic [COORD_W-1:0] t;
      logic [COORD_W-1:0] s;
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } vertex_fields_type;

   typedef struct packed {
      status_type        status;
      logic              last;
      vertex_fields_type fields;
   } emit_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]     req_tuser  = KIND_CMD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;

   // predictor state
   vertex_fields_type     vertex_cache [CACHE_ENTRIES];
   bit                    cache_valid [CACHE_ENTRIES];
   bit                    lighting_on;
   logic [COLOR_W-1:0]    prim_colour;
   int                    pending_count;
   int                    next_slot;

   emit_type              expected_emits [$];
   int                    mismatch_count    = 0;
   int                    effective_requests = 0;
   bit                    idle_on           = 1'b1;
   int                    rsp_hold_cycles   = 0;

   display_list_vertex_cache #(.CACHE_ENTRIES(CACHE_ENTRIES)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void restart_list_model();
      foreach (cache_valid[i]) cache_valid[i] = 1'b0;
      lighting_on   = 1'b1;
      prim_colour   = PRIM_COLOR_RESET;
      pending_count = 0;
   endfunction

   function automatic void push_status(status_type st);
      emit_type e;
      e = '0;
      e.status = st;
      expected_emits = {expected_emits, e};
   endfunction

   function automatic bit usable(logic [IDX_W-1:0] idx);
      if (int'(idx) >= CACHE_ENTRIES) return 1'b0;
      return cache_valid[idx];
   endfunction

   // three cached vertices, or one rejected status if any corner is unusable
   function automatic void predict_triangle(logic [WORD_W-1:0] word);
      logic [IDX_W-1:0] corner [3];
      emit_type e;
      corner[0] = word[23:17];
      corner[1] = word[15:9];
      corner[2] = word[7:1];
      if (!usable(corner[0]) || !usable(corner[1]) || !usable(corner[2])) begin
         push_status(ST_REJECT);
      end else begin
         for (int i = 0; i < 3; i++) begin
            e = '0;
            e.status = ST_VERTEX;
            e.fields = vertex_cache[corner[i]];
            expected_emits = {expected_emits, e};
         end
      end
   endfunction

   function automatic void predict_vertex_load(logic [WORD_W-1:0] word);
      int count, end_index, first;
      count     = word[19:12];
      end_index = word[7:1];
      first     = (end_index >= count) ? end_index - count : CACHE_ENTRIES;
      if (count > CACHE_ENTRIES || first + count > CACHE_ENTRIES) begin
         push_status(ST_BAD_LOAD);
      end else begin
         pending_count = count;
         next_slot     = first;
      end
   endfunction

   // returns 1 when the command does anything at all
   function automatic bit predict_command(logic [WORD_W-1:0] high, logic [WORD_W-1:0] low);
      logic [OPCODE_W-1:0] opcode;
      logic [WORD_W-1:0]   light_word;
      opcode        = high[31:24];
      pending_count = 0;
      case (opcode)
         OP_NOOP, OP_SKIP_E1, OP_SKIP_E3, OP_SKIP_E6, OP_SKIP_E7, OP_SKIP_E8, OP_SKIP_E9,
         OP_SKIP_F1, OP_SKIP_F2, OP_SKIP_F3, OP_SKIP_F4, OP_SKIP_F5, OP_SKIP_FC,
         OP_SKIP_FD: begin
            return 1'b0;
         end
         OP_VTX_LOAD: predict_vertex_load(high);
         OP_TRI1: predict_triangle(high);
         OP_TRI2, OP_TRI2_ALT: begin
            predict_triangle(high);
            predict_triangle(low);
         end
         OP_LIGHTING: begin
            light_word  = {8'h00, high[23:0]} | low;
            lighting_on = light_word[LIGHT_BIT];
         end
         OP_PRIM_COLOR: prim_colour = low;
         OP_CALL: push_status(high[CALL_END_BIT] ? ST_CALL_END : ST_CALL);
         OP_END_LIST: push_status(ST_END);
         default: push_status(ST_UNSUPPORTED);
      endcase
      return 1'b1;
   endfunction

   function automatic bit predict_record(request_fields_type r);
      logic [COLOR_W-1:0] colour;
      vertex_fields_type  entry;
      if (pending_count == 0 || next_slot >= CACHE_ENTRIES) return 1'b0;
      colour      = lighting_on ? prim_colour : r.rgba;
      entry.x     = r.x;
      entry.y     = r.y;
      entry.z     = r.z;
      entry.s     = r.s;
      entry.t     = r.t;
      entry.red   = colour[31:24];
      entry.green = colour[23:16];
      entry.blue  = colour[15:8];
      entry.alpha = colour[7:0];
      vertex_cache[next_slot] = entry;
      cache_valid[next_slot]  = 1'b1;
      next_slot++;
      pending_count--;
      return 1'b1;
   endfunction

   // advance the model by one accepted request and queue what it emits
   function automatic void predict_display_op(logic [KIND_W-1:0] kind, request_fields_type r);
      int  before_size;
      bit  effective;
      before_size = expected_emits.size();
      effective   = 1'b0;
      case (kind)
         KIND_CMD: effective = predict_command(r.command_high, r.command_low);
         KIND_VERTEX: effective = predict_record(r);
         KIND_RESTART: begin
            restart_list_model();
            effective = 1'b1;
         end
         default: effective = 1'b0;
      endcase
      if (expected_emits.size() > before_size)
         expected_emits[expected_emits.size() - 1].last = 1'b1;
      if (effective) effective_requests++;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
   endfunction

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) note_mismatch($sformatf("%s expected %h got %h", name, want, got));
   endfunction

   function automatic void check_emit(logic [STATUS_W-1:0] status, vertex_fields_type got,
                                      logic last);
      emit_type want;
      if (expected_emits.size() == 0) begin
         note_mismatch($sformatf("unexpected result status %0d data %h", status, got));
         return;
      end
      want = expected_emits.pop_front();
      compare_field("status", want.status, status);
      compare_field("out_x", want.fields.x, got.x);
      compare_field("out_y", want.fields.y, got.y);
      compare_field("out_z", want.fields.z, got.z);
      compare_field("out_s", want.fields.s, got.s);
      compare_field("out_t", want.fields.t, got.t);
      compare_field("red", want.fields.red, got.red);
      compare_field("green", want.fields.green, got.green);
      compare_field("blue", want.fields.blue, got.blue);
      compare_field("alpha", want.fields.alpha, got.alpha);
      compare_field("last", want.last, last);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_emit(rsp_tuser, vertex_fields_type'(rsp_tdata), rsp_tlast);
   end

   // result side: random idle per result, plus a long hold-off on request
   initial begin : response_sink
      int idle_cycles;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            idle_cycles     = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            idle_cycles = idle_on ? $urandom_range(0, 4) : 0;
         end
         if (idle_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (idle_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   task automatic send_request(input logic [KIND_W-1:0] kind, input request_fields_type fields);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= fields;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      predict_display_op(kind, fields);
   endtask

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic request_fields_type random_record();
      request_fields_type r;
      r.command_high = $urandom;
      r.command_low  = $urandom;
      r.x            = pick_coord();
      r.y            = pick_coord();
      r.z            = pick_coord();
      r.s            = pick_coord();
      r.t            = pick_coord();
      case ($urandom_range(0, 9))
         0: r.rgba = 32'h0000_0000;
         1: r.rgba = 32'hffff_ffff;
         default: r.rgba = $urandom;
      endcase
      return r;
   endfunction

   // every coordinate at one extreme, colour at the matching extreme
   function automatic request_fields_type extreme_record(bit high_side);
      request_fields_type r;
      r      = random_record();
      r.x    = high_side ? 16'h7fff : 16'h8000;
      r.y    = r.x;
      r.z    = r.x;
      r.s    = r.x;
      r.t    = r.x;
      r.rgba = high_side ? 32'hffff_ffff : 32'h0000_0000;
      return r;
   endfunction

   // triangle indices in bits 23..17, 15..9, 7..1; the spare bits are random
   function automatic logic [WORD_W-1:0] tri_word(logic [OPCODE_W-1:0] op, int a, int b, int c);
      logic [31:0] spare;
      spare = $urandom;
      return {op, IDX_W'(a), spare[0], IDX_W'(b), spare[1], IDX_W'(c), spare[2]};
   endfunction

   function automatic logic [WORD_W-1:0] load_word(int count, int end_index);
      logic [31:0] spare;
      spare = $urandom;
      return {OP_VTX_LOAD, spare[3:0], 8'(count), spare[7:4], IDX_W'(end_index), spare[8]};
   endfunction

   task automatic send_command(input logic [WORD_W-1:0] high, input logic [WORD_W-1:0] low);
      request_fields_type r;
      r              = random_record();
      r.command_high = high;
      r.command_low  = low;
      send_request(KIND_CMD, r);
   endtask

   task automatic load_vertices(input int count, input int end_index, input int records);
      send_command(load_word(count, end_index), $urandom);
      repeat (records) send_request(KIND_VERTEX, random_record());
   endtask

   // mostly a valid cached index, sometimes anything the field can hold
   function automatic int pick_index();
      int idx;
      if ($urandom_range(0, 9) < 8) begin
         repeat (8) begin
            idx = $urandom_range(0, CACHE_ENTRIES - 1);
            if (cache_valid[idx]) return idx;
         end
      end
      return $urandom_range(0, 127);
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      // triangle on an empty cache is rejected
      send_command(tri_word(OP_TRI1, 0, 1, 2), 32'h0);
      // slots 0 and 1 with extreme records while lighting is on
      send_command(load_word(2, 2), 32'h0);
      send_request(KIND_VERTEX, extreme_record(1'b0));
      send_request(KIND_VERTEX, extreme_record(1'b1));
      // lighting off, new primitive colour, raw colours into the top slots
      send_command({OP_LIGHTING, 24'h000000}, 32'h0000_0000);
      send_command({OP_PRIM_COLOR, 24'hffffff}, 32'h1234_5678);
      load_vertices(2, CACHE_ENTRIES, 2);
      // empty load is fine and emits nothing
      send_command(load_word(0, 0), 32'h0);
      // double triangle with both opcodes, the second one naming an index past the cache
      send_command(tri_word(OP_TRI2, 0, 1, 30), tri_word(8'hff, 31, 30, 0));
      send_command(tri_word(OP_TRI2_ALT, 1, 0, 31), tri_word(8'h00, 0, 40, 1));
      // lighting back on through the second word, slot 2 takes the primitive colour
      send_command({OP_LIGHTING, 24'h000000}, 32'h0002_0000);
      load_vertices(1, 3, 1);
      send_command(tri_word(OP_TRI1, 2, 1, 0), 32'h0);
      // status commands and an ignored opcode
      send_command({OP_CALL, 24'h010000}, 32'hffff_ffff);
      send_command({OP_CALL, 24'hfeffff}, 32'h0);
      send_command({OP_END_LIST, 24'h0}, 32'h0);
      send_command({8'h02, 24'h0}, 32'h0);
      send_command({OP_SKIP_FD, 24'hffffff}, 32'hffff_ffff);
      // bad loads: too many, end below count, range past the cache
      send_command(load_word(33, 40), 32'h0);
      send_command(load_word(5, 2), 32'h0);
      send_command(load_word(10, 50), 32'h0);
      // load cut short by a command, then a stray record
      load_vertices(3, 8, 1);
      send_command(tri_word(OP_TRI1, 5, 5, 5), 32'h0);
      send_request(KIND_VERTEX, random_record());
      send_command(tri_word(OP_TRI1, 5, 6, 7), 32'h0);
      // unused kind, restart, then everything is invalid again
      send_request(2'd3, random_record());
      send_request(KIND_RESTART, random_record());
      send_command(tri_word(OP_TRI1, 0, 0, 0), 32'h0);
   endtask

   task automatic test_random_lists(input int target);
      int start_count, choice, count, end_index, records;
      logic [OPCODE_W-1:0] op;
      start_count = effective_requests;
      while (effective_requests - start_count < target) begin
         if ($urandom_range(0, 29) == 0) idle_on = ($urandom_range(0, 3) != 0);
         choice = $urandom_range(0, 99);
         if (choice < 35) begin
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
            if (count <= CACHE_ENTRIES && $urandom_range(0, 9) != 0)
               end_index = $urandom_range(0, CACHE_ENTRIES - count) + count;
            else
               end_index = $urandom_range(0, 127);
            records = count;
            if ($urandom_range(0, 9) == 0) records = $urandom_range(0, count + 2);
            load_vertices(count, end_index, records);
         end else if (choice < 70) begin
            case ($urandom_range(0, 2))
               0: op = OP_TRI1;
               1: op = OP_TRI2;
               default: op = OP_TRI2_ALT;
            endcase
            send_command(tri_word(op, pick_index(), pick_index(), pick_index()),
                         tri_word(8'($urandom), pick_index(), pick_index(), pick_index()));
         end else if (choice < 77) begin
            send_command({OP_LIGHTING, 24'($urandom)}, $urandom);
         end else if (choice < 82) begin
            send_command({OP_PRIM_COLOR, 24'($urandom)}, $urandom);
         end else if (choice < 90) begin
            case ($urandom_range(0, 3))
               0: op = OP_CALL;
               1: op = OP_END_LIST;
               2: op = SKIP_OPCODES[$urandom_range(0, 13)];
               default: op = 8'($urandom);
            endcase
            send_command({op, 24'($urandom)}, $urandom);
         end else if (choice < 93) begin
            send_request(KIND_RESTART, random_record());
         end else begin
            // noise: any kind with arbitrary contents
            send_request(KIND_W'($urandom_range(0, 3)), random_record());
         end
      end
   endtask

   // sink holds off while double triangles keep coming, so the block has to stall
   task automatic test_backpressure();
      idle_on = 1'b0;
      load_vertices(6, 16, 6);
      rsp_hold_cycles = 150;
      repeat (12)
         send_command(tri_word(OP_TRI2, $urandom_range(10, 15), $urandom_range(10, 15),
                               $urandom_range(10, 15)),
                      tri_word(OP_TRI2, $urandom_range(10, 15), $urandom_range(10, 15),
                               $urandom_range(10, 15)));
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- run

   initial begin
      next_slot = 0;
      restart_list_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_lists(100);
      test_backpressure();
      test_random_lists(60);
      req_tvalid <= 1'b0;
      while (expected_emits.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
